FILE: rtl/core/sse_pkg.sv
// Shared constants, codes and link types for the sorted stack engine.
`default_nettype none

package sse_pkg;

  // Stack geometry and field widths
  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int FUNC_W = 3;
  localparam int FILL_W = 5;

  // Request operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_BOTTOM = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SORTED = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SORT   = 3'd4;

  // Commands broadcast to every cell
  localparam logic [2:0] CMD_IDLE   = 3'd0;
  localparam logic [2:0] CMD_PUSH   = 3'd1;
  localparam logic [2:0] CMD_POP    = 3'd2;
  localparam logic [2:0] CMD_BOTTOM = 3'd3;
  localparam logic [2:0] CMD_SORTED = 3'd4;
  localparam logic [2:0] CMD_SWAP   = 3'd5;

  // Value returned by a pop on an empty stack, also the floor below cell 0 in a sort
  localparam logic signed [WORD_W-1:0] EMPTY_MARK = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [2:0]               code;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  // Travels from a cell to the cell above it
  typedef struct packed {
    logic                     occ;
    logic                     gt;
    logic signed [WORD_W-1:0] data;
  } up_link_t;

  // Travels from a cell to the cell below it
  typedef struct packed {
    logic                     occ;
    logic                     ge;
    logic signed [WORD_W-1:0] data;
    logic signed [WORD_W-1:0] top;
  } dn_link_t;

endpackage

`default_nettype wire

FILE: rtl/core/sse_if.sv
// Request and response channel interfaces of the sorted stack engine.
`default_nettype none

interface sse_req_if;
  import sse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface sse_rsp_if;
  import sse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] popped;
  logic                     was_empty;
  logic                     overflow;
  logic [FILL_W-1:0]        fill;

  modport source (output valid, output popped, output was_empty, output overflow,
                  output fill, input ready);
  modport sink   (input valid, input popped, input was_empty, input overflow,
                  input fill, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sse_cell.sv
// One stack cell: holds one entry and its occupied bit, trades data with both neighbors.
`default_nettype none

module sse_cell import sse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cmd_t     cmd,
  input  wire logic     pair_up,
  input  wire up_link_t from_dn,
  input  wire dn_link_t from_up,
  output up_link_t      to_up,
  output dn_link_t      to_dn
);

  logic                     occ;
  logic                     occ_next;
  logic signed [WORD_W-1:0] data;
  logic signed [WORD_W-1:0] data_next;
  logic                     gt;
  logic                     ge;
  logic                     is_top;

  // Flag entries greater than the insert value and fold the flags from above
  assign gt     = occ && (data > cmd.value);
  assign ge     = from_up.ge | gt;
  assign is_top = occ && !from_up.occ;

  // Links to neighbors
  assign to_up.occ  = occ;
  assign to_up.gt   = gt;
  assign to_up.data = data;
  assign to_dn.occ  = occ;
  assign to_dn.ge   = ge;
  assign to_dn.data = data;
  assign to_dn.top  = is_top ? data : from_up.top;

  // Apply the broadcast command
  always_comb begin
    occ_next  = occ;
    data_next = data;
    case (cmd.code)
      CMD_PUSH: begin
        if (!occ && from_dn.occ) begin
          occ_next  = 1'b1;
          data_next = cmd.value;
        end
      end
      CMD_POP: begin
        if (is_top) begin
          occ_next = 1'b0;
        end
      end
      CMD_BOTTOM: begin
        occ_next  = from_dn.occ;
        data_next = from_dn.data;
      end
      CMD_SORTED: begin
        occ_next = occ | from_dn.occ;
        if (!ge) begin
          data_next = from_dn.gt ? cmd.value : from_dn.data;
        end
      end
      CMD_SWAP: begin
        if (pair_up) begin
          if (from_up.occ && (data < from_up.data)) begin
            data_next = from_up.data;
          end
        end else begin
          if (occ && (from_dn.data < data)) begin
            data_next = from_dn.data;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  // Entry data needs no reset
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_stack_engine_unit.sv
// Sorted stack engine: a row of DEPTH cells with a sequencer and a response register.
// Push, pop, push at bottom and sorted insert: a request is accepted every cycle while no
// sort runs and the response register drains, with the response registered in the next cycle.
// Sort-all runs odd-even transposition passes over the cell row, then responds; requests
// are held off until the sequencer is idle again.
// Synchronous reset empties the stack and drops any pending response.
`default_nettype none

module sorted_stack_engine_unit import sse_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  sse_req_if.sink   req,
  sse_rsp_if.source rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SORT = 1'b1;

  logic                     state;
  logic                     state_next;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         sort_cnt;
  logic [CNT_W-1:0]         sort_cnt_next;
  logic                     rsp_valid;
  logic                     rsp_valid_next;
  logic signed [WORD_W-1:0] popped;
  logic signed [WORD_W-1:0] popped_next;
  logic                     was_empty;
  logic                     was_empty_next;
  logic                     overflow;
  logic                     overflow_next;
  logic [FILL_W-1:0]        fill;
  logic [FILL_W-1:0]        fill_next;

  logic                     out_free;
  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     phase;
  cmd_t                     cmd;
  up_link_t                 up_link [DEPTH];
  dn_link_t                 dn_link [DEPTH];
  up_link_t                 floor_link;
  dn_link_t                 ceil_link;

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign phase     = sort_cnt[0];

  assign rsp.valid     = rsp_valid;
  assign rsp.popped    = popped;
  assign rsp.was_empty = was_empty;
  assign rsp.overflow  = overflow;
  assign rsp.fill      = fill;

  // Boundaries of the cell row
  assign floor_link.occ  = 1'b1;
  assign floor_link.gt   = 1'b1;
  assign floor_link.data = (cmd.code == CMD_SWAP) ? EMPTY_MARK : cmd.value;
  assign ceil_link.occ   = 1'b0;
  assign ceil_link.ge    = 1'b0;
  assign ceil_link.data  = '0;
  assign ceil_link.top   = '0;

  // Cell row, index 0 is the bottom of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    up_link_t cell_dn;
    dn_link_t cell_up;
    logic     cell_pair_up;

    if (i == 0) begin : g_bot
      assign cell_dn = floor_link;
    end else begin : g_mid_dn
      assign cell_dn = up_link[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign cell_up = ceil_link;
    end else begin : g_mid_up
      assign cell_up = dn_link[i+1];
    end

    assign cell_pair_up = phase ^ 1'(i % 2);

    sse_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .pair_up (cell_pair_up),
      .from_dn (cell_dn),
      .from_up (cell_up),
      .to_up   (up_link[i]),
      .to_dn   (dn_link[i])
    );
  end

  // Decode requests, sequence the sort and build the response
  always_comb begin
    state_next     = state;
    count_next     = count;
    sort_cnt_next  = sort_cnt;
    rsp_valid_next = rsp_valid && !rsp.ready;
    popped_next    = popped;
    was_empty_next = was_empty;
    overflow_next  = overflow;
    fill_next      = fill;
    cmd.code       = CMD_IDLE;
    cmd.value      = req.value;

    if (state == ST_SORT) begin
      if (sort_cnt != '0) begin
        cmd.code      = CMD_SWAP;
        sort_cnt_next = sort_cnt - 1'b1;
      end else if (out_free) begin
        state_next     = ST_IDLE;
        rsp_valid_next = 1'b1;
        popped_next    = '0;
        was_empty_next = 1'b0;
        overflow_next  = 1'b0;
        fill_next      = FILL_W'(count);
      end
    end else if (accept) begin
      rsp_valid_next = 1'b1;
      popped_next    = '0;
      was_empty_next = 1'b0;
      overflow_next  = 1'b0;
      case (req.func)
        FN_PUSH, FN_BOTTOM, FN_SORTED: begin
          if (full) begin
            overflow_next = 1'b1;
          end else begin
            count_next = count + 1'b1;
            case (req.func)
              FN_PUSH:   cmd.code = CMD_PUSH;
              FN_BOTTOM: cmd.code = CMD_BOTTOM;
              default:   cmd.code = CMD_SORTED;
            endcase
          end
        end
        FN_POP: begin
          if (empty) begin
            popped_next    = EMPTY_MARK;
            was_empty_next = 1'b1;
          end else begin
            cmd.code    = CMD_POP;
            popped_next = dn_link[0].top;
            count_next  = count - 1'b1;
          end
        end
        FN_SORT: begin
          rsp_valid_next = 1'b0;
          state_next     = ST_SORT;
          sort_cnt_next  = CNT_W'(DEPTH);
        end
        default: begin
        end
      endcase
      fill_next = FILL_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      sort_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      sort_cnt  <= sort_cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Response payload holds without reset
  always_ff @(posedge clk) begin
    popped    <= popped_next;
    was_empty <= was_empty_next;
    overflow  <= overflow_next;
    fill      <= fill_next;
  end

endmodule

`default_nettype wire
